[rtl/pnps_pkg.sv]
// shared constants, types and helper functions of the priority scheduler
// used by pnps_pick and priority_nonpreemptive_scheduler; no dependencies
package pnps_pkg;

  localparam int MAX_JOBS = 32;
  localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);

  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int ID_W    = 6;
  localparam int T_W     = 22;
  localparam int S_W     = 28;

  localparam int ENTRY_W     = ARR_W + BURST_W + PRIO_W;
  localparam int IN_TDATA_W  = ((ENTRY_W + 7) / 8) * 8;
  localparam int OUT_W       = ID_W + 5 * T_W + 3 * S_W + T_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [T_W-1:0] T_MAX = '1;
  localparam logic [S_W-1:0] S_MAX = '1;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arrival;
  } entry_t;

  typedef struct packed {
    logic               any;
    logic [IDX_W-1:0]   idx;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [T_W-1:0]     start;
  } pick_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_CALC1,
    S_CALC2,
    S_CALC3,
    S_EMIT
  } state_t;

  function automatic logic [T_W-1:0] sub_floor(input logic [T_W-1:0] a,
                                               input logic [T_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  function automatic logic [T_W-1:0] add_sat_t(input logic [T_W-1:0] a,
                                               input logic [T_W-1:0] b);
    logic [T_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[T_W] ? T_MAX : sum[T_W-1:0];
  endfunction

  function automatic logic [S_W-1:0] add_sat_s(input logic [S_W-1:0] a,
                                               input logic [T_W-1:0] b);
    logic [S_W:0] sum;
    sum = {1'b0, a} + (S_W + 1)'(b);
    return sum[S_W] ? S_MAX : sum[S_W-1:0];
  endfunction

endpackage

[rtl/pnps_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module pnps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/pnps_pick.sv]
// scan unit: compares one stored job per cycle and keeps the ready winner
// and the earliest pending job; depends on pnps_pkg
module pnps_pick (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic                     in_valid,
  input  logic [pnps_pkg::IDX_W-1:0] in_idx,
  input  pnps_pkg::entry_t         in_entry,
  input  logic                     in_done,
  input  logic [pnps_pkg::T_W-1:0] now,
  output pnps_pkg::pick_t          pick
);

  logic                            r_found;
  logic [pnps_pkg::IDX_W-1:0]      r_idx;
  logic [pnps_pkg::ARR_W-1:0]      r_arr;
  logic [pnps_pkg::BURST_W-1:0]    r_burst;
  logic [pnps_pkg::PRIO_W-1:0]     r_prio;
  logic                            e_found;
  logic [pnps_pkg::IDX_W-1:0]      e_idx;
  logic [pnps_pkg::ARR_W-1:0]      e_arr;
  logic [pnps_pkg::BURST_W-1:0]    e_burst;
  logic [pnps_pkg::PRIO_W-1:0]     e_prio;
  logic                            pend;
  logic                            ready;
  logic                            take_r;
  logic                            take_e;

  always_comb begin
    pend   = in_valid && !in_done;
    ready  = pend && (pnps_pkg::T_W'(in_entry.arrival) <= now);
    take_r = ready && (!r_found || (in_entry.prio > r_prio) ||
             ((in_entry.prio == r_prio) && (in_entry.arrival < r_arr)));
    take_e = pend && (!e_found || (in_entry.arrival < e_arr) ||
             ((in_entry.arrival == e_arr) && (in_entry.prio > e_prio)));
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      r_found <= 1'b0;
      e_found <= 1'b0;
    end else begin
      if (take_r) begin
        r_found <= 1'b1;
      end
      if (take_e) begin
        e_found <= 1'b1;
      end
    end
    if (take_r) begin
      r_idx   <= in_idx;
      r_arr   <= in_entry.arrival;
      r_burst <= in_entry.burst;
      r_prio  <= in_entry.prio;
    end
    if (take_e) begin
      e_idx   <= in_idx;
      e_arr   <= in_entry.arrival;
      e_burst <= in_entry.burst;
      e_prio  <= in_entry.prio;
    end
  end

  // no ready job: time jumps to the earliest pending arrival
  always_comb begin
    pick.any     = r_found || e_found;
    pick.idx     = r_found ? r_idx : e_idx;
    pick.arrival = r_found ? r_arr : e_arr;
    pick.burst   = r_found ? r_burst : e_burst;
    pick.start   = r_found ? now : pnps_pkg::T_W'(e_arr);
  end

endmodule

[rtl/priority_nonpreemptive_scheduler.sv]
// Non-preemptive priority scheduler. Jobs are loaded one request per cycle
// into a job memory; the request with tlast set, or the one that fills all
// MAX_JOBS slots, closes the batch. Each dispatch then reads all N loaded jobs
// from the memory, one per cycle, and then passes a read-latency state (DRAIN),
// three arithmetic states (CALC1 to CALC3) and one output state (EMIT). No new
// job is accepted until the last result of the batch has been handed to the
// output register. Depends on pnps_pkg, pnps_ram and pnps_pick.
module priority_nonpreemptive_scheduler (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // arrival[15:0], burst[31:16], prio[39:32]
  input  logic [pnps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // job_id, start_res, finish, turnaround, waiting, response,
  // sum_turnaround, sum_waiting, sum_response, sum_idle, zero pad
  output logic [pnps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast
);

  pnps_pkg::state_t               state;
  pnps_pkg::state_t               state_next;

  logic [pnps_pkg::CNT_W-1:0]     job_count;
  logic [pnps_pkg::CNT_W-1:0]     dispatched;
  logic [pnps_pkg::CNT_W-1:0]     dispatched_inc;
  logic [pnps_pkg::CNT_W-1:0]     scan_cnt;
  logic [pnps_pkg::IDX_W-1:0]     rd_idx_q;
  logic                           rd_valid;
  logic [pnps_pkg::MAX_JOBS-1:0]  done;

  logic [pnps_pkg::T_W-1:0]       now;
  logic [pnps_pkg::T_W-1:0]       last_finish;
  logic [pnps_pkg::S_W-1:0]       total_turn;
  logic [pnps_pkg::S_W-1:0]       total_wait;
  logic [pnps_pkg::S_W-1:0]       total_resp;
  logic [pnps_pkg::T_W-1:0]       total_idle;
  logic [pnps_pkg::S_W-1:0]       wait_sum;

  logic [pnps_pkg::T_W-1:0]       st;
  logic [pnps_pkg::T_W-1:0]       fin;
  logic [pnps_pkg::T_W-1:0]       rt;
  logic [pnps_pkg::T_W-1:0]       gap;
  logic [pnps_pkg::T_W-1:0]       tat;
  logic [pnps_pkg::T_W-1:0]       wt;
  logic [pnps_pkg::IDX_W-1:0]     sel_idx;
  logic [pnps_pkg::ARR_W-1:0]     sel_arr;
  logic [pnps_pkg::BURST_W-1:0]   sel_burst;

  logic                           load_fire;
  logic                           batch_close;
  logic                           scan_issue;
  logic                           scan_clear;
  logic                           emit_fire;
  logic                           last_dispatch;

  pnps_pkg::entry_t               wr_entry;
  pnps_pkg::entry_t               rd_entry;
  pnps_pkg::pick_t                pick;

  assign wr_entry       = pnps_pkg::entry_t'(s_axis_tdata[pnps_pkg::ENTRY_W-1:0]);
  assign dispatched_inc = dispatched + pnps_pkg::CNT_W'(1);
  assign last_dispatch  = (dispatched_inc == job_count);
  assign wait_sum       = pnps_pkg::add_sat_s(total_wait, wt);

  pnps_ram #(
    .WIDTH (pnps_pkg::ENTRY_W),
    .DEPTH (pnps_pkg::MAX_JOBS)
  ) u_jobs (
    .clk   (clk),
    .we    (load_fire),
    .waddr (job_count[pnps_pkg::IDX_W-1:0]),
    .wdata (wr_entry),
    .raddr (scan_cnt[pnps_pkg::IDX_W-1:0]),
    .rdata (rd_entry)
  );

  pnps_pick u_pick (
    .clk      (clk),
    .rst      (rst),
    .clear    (scan_clear),
    .in_valid (rd_valid),
    .in_idx   (rd_idx_q),
    .in_entry (rd_entry),
    .in_done  (done[rd_idx_q]),
    .now      (now),
    .pick     (pick)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pnps_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    load_fire     = 1'b0;
    batch_close   = 1'b0;
    scan_issue    = 1'b0;
    scan_clear    = 1'b0;
    emit_fire     = 1'b0;
    case (state)
      pnps_pkg::S_LOAD: begin
        s_axis_tready = !rst;
        load_fire     = s_axis_tvalid && s_axis_tready;
        batch_close   = load_fire && (s_axis_tlast ||
                        (job_count == pnps_pkg::CNT_W'(pnps_pkg::MAX_JOBS - 1)));
        if (batch_close) begin
          scan_clear = 1'b1;
          state_next = pnps_pkg::S_SCAN;
        end
      end
      pnps_pkg::S_SCAN: begin
        scan_issue = 1'b1;
        if (scan_cnt == job_count - pnps_pkg::CNT_W'(1)) begin
          state_next = pnps_pkg::S_DRAIN;
        end
      end
      pnps_pkg::S_DRAIN: state_next = pnps_pkg::S_CALC1;
      pnps_pkg::S_CALC1: state_next = pnps_pkg::S_CALC2;
      pnps_pkg::S_CALC2: state_next = pnps_pkg::S_CALC3;
      pnps_pkg::S_CALC3: state_next = pnps_pkg::S_EMIT;
      pnps_pkg::S_EMIT: begin
        emit_fire = !m_axis_tvalid || m_axis_tready;
        if (emit_fire) begin
          if (last_dispatch) begin
            state_next = pnps_pkg::S_LOAD;
          end else begin
            scan_clear = 1'b1;
            state_next = pnps_pkg::S_SCAN;
          end
        end
      end
      default: state_next = pnps_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_count     <= '0;
      dispatched    <= '0;
      scan_cnt      <= '0;
      rd_valid      <= 1'b0;
      done          <= '0;
      now           <= '0;
      last_finish   <= '0;
      total_turn    <= '0;
      total_wait    <= '0;
      total_resp    <= '0;
      total_idle    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rd_valid <= scan_issue;
      if (load_fire) begin
        job_count <= job_count + pnps_pkg::CNT_W'(1);
      end
      if (batch_close) begin
        dispatched  <= '0;
        done        <= '0;
        now         <= '0;
        last_finish <= '0;
        total_turn  <= '0;
        total_wait  <= '0;
        total_resp  <= '0;
        total_idle  <= '0;
      end
      if (scan_clear) begin
        scan_cnt <= '0;
      end else if (scan_issue) begin
        scan_cnt <= scan_cnt + pnps_pkg::CNT_W'(1);
      end
      if (state == pnps_pkg::S_CALC2) begin
        total_resp <= pnps_pkg::add_sat_s(total_resp, rt);
        total_idle <= pnps_pkg::add_sat_t(total_idle, gap);
      end
      if (state == pnps_pkg::S_CALC3) begin
        total_turn <= pnps_pkg::add_sat_s(total_turn, tat);
      end
      if (emit_fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (emit_fire) begin
        total_wait    <= wait_sum;
        done[sel_idx] <= 1'b1;
        now           <= fin;
        last_finish   <= fin;
        dispatched    <= dispatched_inc;
        if (last_dispatch) begin
          job_count <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_q <= scan_cnt[pnps_pkg::IDX_W-1:0];
    if (state == pnps_pkg::S_CALC1) begin
      st        <= pick.start;
      fin       <= pnps_pkg::add_sat_t(pick.start, pnps_pkg::T_W'(pick.burst));
      rt        <= pnps_pkg::sub_floor(pick.start, pnps_pkg::T_W'(pick.arrival));
      gap       <= pnps_pkg::sub_floor(pick.start, last_finish);
      sel_idx   <= pick.idx;
      sel_arr   <= pick.arrival;
      sel_burst <= pick.burst;
    end
    if (state == pnps_pkg::S_CALC2) begin
      tat <= pnps_pkg::sub_floor(fin, pnps_pkg::T_W'(sel_arr));
    end
    if (state == pnps_pkg::S_CALC3) begin
      wt <= pnps_pkg::sub_floor(tat, pnps_pkg::T_W'(sel_burst));
    end
    if (emit_fire) begin
      m_axis_tdata <= pnps_pkg::OUT_TDATA_W'({total_idle, total_resp, wait_sum,
                      total_turn, rt, wt, tat, fin, st,
                      pnps_pkg::ID_W'(sel_idx) + pnps_pkg::ID_W'(1)});
      m_axis_tlast <= last_dispatch;
    end
  end

  a_pick_found: assert property (@(posedge clk) disable iff (rst)
    (state == pnps_pkg::S_CALC1) |-> pick.any)
    else $error("no pending job found at end of scan");

  a_count_order: assert property (@(posedge clk) disable iff (rst)
    (state != pnps_pkg::S_LOAD) |-> (dispatched < job_count))
    else $error("dispatch count reached job count outside load");

  a_job_bound: assert property (@(posedge clk) disable iff (rst)
    job_count <= pnps_pkg::CNT_W'(pnps_pkg::MAX_JOBS))
    else $error("job count beyond store depth");

  a_final_return: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && last_dispatch) |=> (state == pnps_pkg::S_LOAD) && (job_count == '0))
    else $error("batch did not return to loading after last dispatch");

  a_done_mark: assert property (@(posedge clk) disable iff (rst)
    emit_fire |=> done[$past(sel_idx)])
    else $error("dispatched job not marked done");

endmodule
